// File: sv/pca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants for the palette color allocator: table geometry,
// channel reduction, the search token that walks the cell row and the
// broadcast write bundle.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;

    localparam int CHAN_IN_W     = 16;
    localparam int CHANNEL_SHIFT = 10;
    localparam int CHAN_W        = CHAN_IN_W - CHANNEL_SHIFT;
    localparam int ENTRY_W       = 3 * CHAN_W;

    localparam int PAL_INDEX_W   = 8;
    localparam int S_TDATA_W     = 3 * CHAN_IN_W;
    localparam int M_TDATA_W     = 16;

    // Search token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [ENTRY_W-1:0] colour;
    } t_token;

    // Table write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] data;
    } t_wr;

    // Keep the top six bits of each channel and pack red, green, blue
    function automatic logic [ENTRY_W-1:0] pack_colour(
        input logic [CHAN_IN_W-1:0] red,
        input logic [CHAN_IN_W-1:0] green,
        input logic [CHAN_IN_W-1:0] blue
    );
        pack_colour = {red[CHAN_IN_W-1:CHANNEL_SHIFT],
                       green[CHAN_IN_W-1:CHANNEL_SHIFT],
                       blue[CHAN_IN_W-1:CHANNEL_SHIFT]};
    endfunction

endpackage

// File: sv/pca_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_cell
// One palette entry. Compares the passing search token against its stored
// color when the entry is in use, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module pca_cell
    import pca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic [CNT_W-1:0] i_used,
    input  t_wr              i_wr,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic [ENTRY_W-1:0] r_entry;
    t_token             r_tok;
    t_token             n_tok;
    logic               w_in_use;
    logic               w_match;

    // Store the entry on a write addressed to this cell
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    // First match in the used range claims the token
    assign w_in_use = ({1'b0, i_cell_idx} < i_used);
    assign w_match  = i_tok.valid && !i_tok.found && w_in_use && (r_entry == i_tok.colour);

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.found = 1'b1;
            n_tok.index = i_cell_idx;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found  <= n_tok.found;
        r_tok.index  <= n_tok.index;
        r_tok.colour <= n_tok.colour;
    end

    assign o_tok = r_tok;

endmodule

// File: sv/palette_color_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_allocator_top
// Lookup-or-insert color palette built as a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one color request per beat (red, green, blue, 16
//   bits each); only bits 15..10 of each channel are kept. Master channel
//   returns one beat per request: the palette index holding the color and a
//   flag set when the table was written (new entry, or overwrite of the last
//   entry once the table is full).
//   A request enters as a token at the head of a row of PALETTE_DEPTH cells
//   and moves one cell per cycle; the first in-use cell with an equal color
//   claims it. From the accepting edge the token passes the cell registers,
//   then the pending result register and the output register to the result
//   beat. One request is in flight at a time: a new request is taken only
//   after the previous result has moved to the output register.
//   A result waiting on a stalled receiver does not block the next request;
//   that request's result is held until the output register frees up.
//   Reset empties the table (use count zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
module palette_color_allocator_top
    import pca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // [15:0] red, [31:16] green, [47:32] blue
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] palette_index, [8] entry_written, [15:9] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_pend_wr;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_wr;

    t_token           w_tok [0:PALETTE_DEPTH];
    t_token           w_exit;
    t_wr              w_wr;
    logic             w_s_acc;
    logic             w_m_acc;
    logic             w_exit_hit;
    logic             w_full;
    logic             w_out_load;
    logic [IDX_W-1:0] w_slot;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = m_axis_tvalid && m_axis_tready;

    // Inject a token at the head of the row
    assign w_tok[0] = {w_s_acc, 1'b0, IDX_W'(0),
                       pack_colour(s_axis_tdata[CHAN_IN_W-1:0],
                                   s_axis_tdata[2*CHAN_IN_W-1:CHAN_IN_W],
                                   s_axis_tdata[3*CHAN_IN_W-1:2*CHAN_IN_W])};

    // Row of compare cells
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        pca_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_used     (r_used),
            .i_wr       (w_wr),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign w_exit     = w_tok[PALETTE_DEPTH];
    assign w_exit_hit = w_exit.valid && (r_state == ST_SEARCH);
    assign w_full     = (r_used == CNT_W'(PALETTE_DEPTH));

    // Append at the next free entry, or overwrite the last one when full
    always_comb begin
        w_slot = w_full ? IDX_W'(PALETTE_DEPTH - 1) : r_used[IDX_W-1:0];
        n_used = w_full ? r_used : r_used + 1'b1;
        w_wr.en   = w_exit_hit && !w_exit.found;
        w_wr.idx  = w_slot;
        w_wr.data = w_exit.colour;
    end

    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Sequence one request at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_s_acc) n_state = ST_SEARCH;
            ST_SEARCH: if (w_exit.valid) n_state = ST_DONE;
            ST_DONE:   if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control state and use count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr.en) begin
                r_used <= n_used;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_m_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the finished result, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (w_exit_hit) begin
            r_pend_idx <= w_exit.found ? w_exit.index : w_slot;
            r_pend_wr  <= !w_exit.found;
        end
        if (w_out_load) begin
            r_out_idx <= r_pend_idx;
            r_out_wr  <= r_pend_wr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_wr, PAL_INDEX_W'(r_out_idx)});

`ifndef NO_ASSERTIONS
    // No token leaves the row while a new request may enter
    a_idle_no_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_exit.valid)
        else $error("search token exited while idle");

    // Use count never passes the table depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(PALETTE_DEPTH))
        else $error("entry count beyond table depth");

    // An append grows the count by exactly one
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit_hit && !w_exit.found && !w_full) |=> (r_used == $past(r_used) + 1'b1))
        else $error("append did not advance the entry count");

    // A match always points inside the used part of the table
    a_match_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_wr) |-> ({1'b0, r_out_idx} < r_used))
        else $error("matched index outside used entries");
`endif

endmodule

// File: dv/palette_color_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_allocator_top_tb
// Self-checking bench for the palette color allocator. Color requests go in
// on the slave stream. A scoreboard keeps its own copy of the palette and of
// the fill count. From these it predicts the index and the write flag for
// every request and checks each result beat in order. A directed opening
// covers channel extremes, packing order and the ignored low bits. A long
// random phase follows, weighted toward repeats, so that hits, appends and
// overwrites of the last entry once the table is full all get exercised.
// ----------------------------------------------------------------------------

import pca_pkg::*;

// Expected result of one palette lookup
typedef struct packed {
    logic [PAL_INDEX_W-1:0] index;
    logic                   written;
} t_lookup_result;

class palette_scoreboard;

    logic [ENTRY_W-1:0] shadow_palette [PALETTE_DEPTH];
    int unsigned        shadow_fill = 0;
    t_lookup_result     pending_lookups [$];

    int unsigned errors     = 0;
    int unsigned checked    = 0;
    int unsigned hits       = 0;
    int unsigned appends    = 0;
    int unsigned overwrites = 0;

    // Print one line per mismatch and count it
    task report_mismatch(input string what, input int unsigned want,
                         input int unsigned got);
        errors++;
        $display("%0t MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Look up or insert one accepted request and queue the expected result
    function void note_request(input logic [S_TDATA_W-1:0] beat);
        logic [CHAN_IN_W-1:0] red, green, blue;
        logic [CHAN_W-1:0]    red6, green6, blue6;
        logic [ENTRY_W-1:0]   colour;
        t_lookup_result       res;
        int unsigned          slot;
        bit                   hit;
        red    = beat[CHAN_IN_W-1:0];
        green  = beat[2*CHAN_IN_W-1:CHAN_IN_W];
        blue   = beat[3*CHAN_IN_W-1:2*CHAN_IN_W];
        red6   = CHAN_W'(red   >> CHANNEL_SHIFT);
        green6 = CHAN_W'(green >> CHANNEL_SHIFT);
        blue6  = CHAN_W'(blue  >> CHANNEL_SHIFT);
        colour = {red6, green6, blue6};
        hit    = 1'b0;
        slot   = 0;
        // Lowest matching in-use entry wins
        for (int i = 0; i < shadow_fill; i++) begin
            if (!hit && shadow_palette[i] == colour) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (hit) begin
            hits++;
        end else begin
            // Append, or overwrite the last entry once the table is full
            if (shadow_fill < PALETTE_DEPTH) begin
                shadow_fill++;
                appends++;
            end else begin
                overwrites++;
            end
            slot = shadow_fill - 1;
            shadow_palette[slot] = colour;
        end
        res.index   = PAL_INDEX_W'(slot);
        res.written = !hit;
        pending_lookups.push_back(res);
    endfunction

    // Compare one result beat against the oldest expectation
    task check_result(input logic [M_TDATA_W-1:0] beat);
        t_lookup_result want;
        if (pending_lookups.size() == 0) begin
            report_mismatch("result beat with no request outstanding", 0, beat);
        end else begin
            want = pending_lookups.pop_front();
            checked++;
            if (beat[PAL_INDEX_W-1:0] !== want.index)
                report_mismatch("palette_index", want.index, beat[PAL_INDEX_W-1:0]);
            if (beat[PAL_INDEX_W] !== want.written)
                report_mismatch("entry_written", want.written, beat[PAL_INDEX_W]);
            if (beat[M_TDATA_W-1:PAL_INDEX_W+1] !== '0)
                report_mismatch("padding bits", 0, beat[M_TDATA_W-1:PAL_INDEX_W+1]);
        end
    endtask

    function int unsigned outstanding();
        return pending_lookups.size();
    endfunction

endclass

module palette_color_allocator_top_tb;

    localparam int RANDOM_ITEMS  = 1950;
    localparam int IDLE_PERCENT  = 23;
    localparam int STEADY_FIRST  = 700;
    localparam int STEADY_LAST   = 1000;
    localparam int DRAIN_CYCLES  = PALETTE_DEPTH + 16;

    localparam logic [S_TDATA_W-1:0] LOW_BITS_MASK = {3{16'h03FF}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    // Set during the stretch where neither side idles
    bit steady_flow = 1'b0;

    palette_scoreboard palette_sb = new;

    palette_color_allocator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [S_TDATA_W-1:0] rgb(input logic [15:0] red,
                                                 input logic [15:0] green,
                                                 input logic [15:0] blue);
        return {blue, green, red};
    endfunction

    // Drive one request beat, with random idle cycles ahead of it outside the steady stretch
    task automatic drive_color(input logic [S_TDATA_W-1:0] beat);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        palette_sb.note_request(beat);
    endtask

    // Check result beats and stall the master side at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                palette_sb.check_result(m_axis_tdata);
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Main stimulus
    initial begin
        logic [S_TDATA_W-1:0] seen_colors [$];
        logic [S_TDATA_W-1:0] last_color;
        logic [S_TDATA_W-1:0] color;
        int unsigned          pick;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, low bits ignored, extremes and channel packing order
        drive_color(rgb(16'h0000, 16'h0000, 16'h0000));
        drive_color(rgb(16'h03FF, 16'h03FF, 16'h03FF));
        drive_color(rgb(16'hFFFF, 16'hFFFF, 16'hFFFF));
        drive_color(rgb(16'hFC00, 16'hFC00, 16'hFC00));
        drive_color(rgb(16'hFFFF, 16'h0000, 16'h0000));
        drive_color(rgb(16'h0000, 16'hFFFF, 16'h0000));
        drive_color(rgb(16'h0000, 16'h0000, 16'hFFFF));
        drive_color(rgb(16'h0400, 16'h0000, 16'h0000));
        drive_color(rgb(16'h0000, 16'h0400, 16'h0000));
        drive_color(rgb(16'h0000, 16'h0000, 16'h0400));
        drive_color(rgb(16'h0400, 16'h0400, 16'h0400));
        drive_color(rgb(16'hFFFF, 16'h03FF, 16'h0155));
        drive_color(rgb(16'h8000, 16'h8000, 16'h8000));
        drive_color(rgb(16'h0000, 16'hFFFF, 16'hFFFF));
        drive_color(rgb(16'hAAAA, 16'h5555, 16'hAAAA));
        drive_color(rgb(16'h5555, 16'hAAAA, 16'h5555));
        drive_color(rgb(16'hFC01, 16'h0000, 16'h03FE));
        drive_color(rgb(16'h7FFF, 16'h7FFF, 16'h7FFF));
        drive_color(rgb(16'hAAAA, 16'h5555, 16'hAAAA));
        drive_color(rgb(16'h0000, 16'h0000, 16'h0000));

        // Random phase: repeats of earlier colors, the previous color,
        // a coarse grid of extremes, and fully random colors
        last_color = rgb(16'h0000, 16'h0000, 16'h0000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= STEADY_FIRST && n < STEADY_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 40 && seen_colors.size() != 0) begin
                color = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
            end else if (pick < 50) begin
                color = last_color;
            end else if (pick < 60) begin
                color = rgb($urandom_range(0, 1) ? 16'hFC00 : 16'h0000,
                            $urandom_range(0, 1) ? 16'hFC00 : 16'h0000,
                            $urandom_range(0, 1) ? 16'hFC00 : 16'h0000);
            end else begin
                color = S_TDATA_W'({$urandom(), $urandom()});
            end
            // Re-roll the ignored low bits of every channel
            color = (color & ~LOW_BITS_MASK)
                  | (S_TDATA_W'({$urandom(), $urandom()}) & LOW_BITS_MASK);
            drive_color(color);
            last_color = color;
            if (seen_colors.size() < 4096)
                seen_colors.push_back(color);
        end
        steady_flow = 1'b0;

        // Drain and watch for stray beats
        s_axis_tvalid <= 1'b0;
        while (palette_sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d lookups: %0d hits, %0d appends, %0d last-entry overwrites.",
                 palette_sb.checked, palette_sb.hits, palette_sb.appends,
                 palette_sb.overwrites);
        if (palette_sb.errors == 0) begin
            $display("palette_color_allocator_top regression: pass");
        end else begin
            $display("palette_color_allocator_top regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("Timeout with %0d lookups outstanding.", palette_sb.outstanding());
        $display("palette_color_allocator_top regression: fail");
        $finish;
    end

endmodule
